FILE: src/qes_pkg.sv
// Shared types, constants and codes of the quadrature encoder speed block.
package qes_pkg;

  // Default position counter width
  localparam int COUNT_WIDTH_DEF = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REG_W  = 16;
  localparam logic [CFG_REG_W-1:0] PPR_RESET  = 16'd11;
  localparam logic [CFG_REG_W-1:0] GEAR_RESET = 16'd30;

  // Register index codes (word address bit 2)
  localparam logic REG_PPR  = 1'b0;
  localparam logic REG_GEAR = 1'b1;

  // Result field widths
  localparam int OUT_W = 32;
  localparam int RPM_W = 40;

  // Divider widths: 32-bit divisor, quotient kept to 41 bits plus a sticky overflow
  localparam int DEN_W     = 32;
  localparam int QUO_W     = 41;
  localparam int RPM_NUM_W = 44;  // 32-bit speed magnitude times 3840

  // Saturation limits on the magnitude
  localparam logic [QUO_W-1:0] SPD_POS_LIM = 41'h000_7FFF_FFFF;
  localparam logic [QUO_W-1:0] SPD_NEG_LIM = 41'h000_8000_0000;
  localparam logic [QUO_W-1:0] RPM_POS_LIM = 41'h07F_FFFF_FFFF;
  localparam logic [QUO_W-1:0] RPM_NEG_LIM = 41'h080_0000_0000;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_CLR_POS = 2'd2,
    CMD_CLR_SPD = 2'd3
  } qes_cmd_t;

  typedef struct packed {
    qes_cmd_t    cmd;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;
  } qes_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] position;
    logic signed [OUT_W-1:0] window_delta;
    logic signed [OUT_W-1:0] speed_ticks_per_sec;
    logic signed [RPM_W-1:0] rpm_q8;
  } qes_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD_MAG,
    ST_SPD_LOAD,
    ST_SPD_DIV,
    ST_SPD_SAT,
    ST_RPM_MAG,
    ST_RPM_LOAD,
    ST_RPM_DIV,
    ST_RPM_SAT,
    ST_PUSH
  } qes_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic push;
    logic spd_mag;
    logic spd_load;
    logic spd_sat;
    logic rpm_mag;
    logic rpm_load;
    logic rpm_sat;
    logic div_step;
  } qes_dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slow;
    logic div_last;
  } qes_dp_sts_t;

endpackage

FILE: src/qes_div.sv
// Restoring divider, one quotient bit per cycle while step is high, with a saturating quotient.
module qes_div import qes_pkg::*; #(
  parameter int NUM_W = RPM_NUM_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                step,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [QUO_W-1:0]    q_mag,
  output logic                last
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = rem_sh >= {1'b0, den_r};
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    ovf_nxt = ovf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      quo_nxt = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (step) begin
      num_nxt = num_r << 1;
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      ovf_nxt = ovf_r | quo_r[QUO_W-1];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  // Clamp to all ones once a bit fell off the top
  assign q_mag = ovf_r ? '1 : quo_r;
  assign last  = (cnt_r == CNT_W'(1));

endmodule

FILE: src/qes_dp.sv
// Datapath: decoder counters, speed window, configuration registers and RPM.
module qes_dp import qes_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qes_in_t              in_data,
  input  qes_dp_cmd_t          cmd,
  input  logic                 cfg_wr,
  input  logic                 cfg_sel,
  input  logic [CFG_REG_W-1:0] cfg_wdata,
  output logic [CFG_REG_W-1:0] cfg_rdata,
  output qes_dp_sts_t          sts,
  output qes_out_t             out_data
);

  localparam int NUM_W = (CW + 10 > RPM_NUM_W) ? CW + 10 : RPM_NUM_W;
  localparam int MAG_W = (CW > 32) ? CW : 32;

  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        ref_r, ref_nxt;
  logic [CW-1:0]        delta_r, delta_nxt;
  logic [OUT_W-1:0]     speed_r, speed_nxt;
  logic [RPM_W-1:0]     rpm_r, rpm_nxt;
  logic [31:0]          last_ms_r, last_ms_nxt;
  logic [31:0]          dt_r, dt_nxt;
  logic                 prev_a_r, prev_a_nxt;
  logic                 prev_b_r, prev_b_nxt;
  logic [CFG_REG_W-1:0] ppr_r, ppr_nxt;
  logic [CFG_REG_W-1:0] gear_r, gear_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;

  logic [CW-1:0]    pos_s;
  logic [CW-1:0]    delta_abs;
  logic [OUT_W-1:0] speed_abs;
  logic [31:0]      dt;
  logic             chg_a, chg_b;
  logic [NUM_W-1:0] spd_num, rpm_num, div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_load;
  logic [QUO_W-1:0] q_mag;
  logic [QUO_W-1:0] lim;
  logic [QUO_W-1:0] sat_m;
  logic [QUO_W-1:0] signed_m;
  logic             den_zero;

  // Count one x4 step from the pin sample
  always_comb begin
    chg_a = in_data.pin_a ^ prev_a_r;
    chg_b = in_data.pin_b ^ prev_b_r;
    pos_s = pos_r;
    if (chg_a && !chg_b) begin
      pos_s = (in_data.pin_a == in_data.pin_b) ? pos_r + CW'(1) : pos_r - CW'(1);
    end else if (chg_b && !chg_a) begin
      pos_s = (in_data.pin_a != in_data.pin_b) ? pos_r + CW'(1) : pos_r - CW'(1);
    end
  end

  assign dt       = in_data.now_ms - last_ms_r;
  assign sts.slow = (in_data.cmd == CMD_MEASURE) && (dt != 32'd0);

  // Magnitudes and scaled numerators: x1000 = 1024 - 16 - 8, x3840 = 4096 - 256
  assign delta_abs = delta_r[CW-1] ? (CW'(0) - delta_r) : delta_r;
  assign speed_abs = speed_r[OUT_W-1] ? (OUT_W'(0) - speed_r) : speed_r;
  assign spd_num   = NUM_W'({mag_r, 10'b0}) - NUM_W'({mag_r, 4'b0}) - NUM_W'({mag_r, 3'b0});
  assign rpm_num   = NUM_W'({mag_r, 12'b0}) - NUM_W'({mag_r, 8'b0});
  assign div_load  = cmd.spd_load | cmd.rpm_load;
  assign div_num   = cmd.rpm_load ? rpm_num : spd_num;
  assign div_den   = cmd.rpm_load ? (DEN_W'(ppr_r) * DEN_W'(gear_r)) : dt_r;
  assign den_zero  = (ppr_r == '0) || (gear_r == '0);

  qes_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .step  (cmd.div_step),
    .num   (div_num),
    .den   (div_den),
    .q_mag (q_mag),
    .last  (sts.div_last)
  );

  // Saturate the quotient magnitude and put the sign back
  always_comb begin
    if (cmd.rpm_sat) begin
      lim = neg_r ? RPM_NEG_LIM : RPM_POS_LIM;
    end else begin
      lim = neg_r ? SPD_NEG_LIM : SPD_POS_LIM;
    end
    sat_m    = (q_mag > lim) ? lim : q_mag;
    signed_m = neg_r ? (QUO_W'(0) - sat_m) : sat_m;
  end

  // Next state of the block
  always_comb begin
    pos_nxt     = pos_r;
    ref_nxt     = ref_r;
    delta_nxt   = delta_r;
    speed_nxt   = speed_r;
    rpm_nxt     = rpm_r;
    last_ms_nxt = last_ms_r;
    dt_nxt      = dt_r;
    prev_a_nxt  = prev_a_r;
    prev_b_nxt  = prev_b_r;
    ppr_nxt     = ppr_r;
    gear_nxt    = gear_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;

    if (cmd.accept) begin
      pos_nxt    = pos_s;
      prev_a_nxt = in_data.pin_a;
      prev_b_nxt = in_data.pin_b;
      unique case (in_data.cmd)
        CMD_SAMPLE: begin
        end
        CMD_MEASURE: begin
          if (dt != 32'd0) begin
            delta_nxt   = pos_s - ref_r;
            ref_nxt     = pos_s;
            last_ms_nxt = in_data.now_ms;
            dt_nxt      = dt;
          end
        end
        CMD_CLR_POS: begin
          pos_nxt   = '0;
          ref_nxt   = '0;
          delta_nxt = '0;
        end
        CMD_CLR_SPD: begin
          speed_nxt = '0;
          delta_nxt = '0;
          rpm_nxt   = '0;
        end
      endcase
    end

    if (cmd.spd_mag) begin
      neg_nxt = delta_r[CW-1];
      mag_nxt = MAG_W'(delta_abs);
    end
    if (cmd.rpm_mag) begin
      neg_nxt = speed_r[OUT_W-1];
      mag_nxt = MAG_W'(speed_abs);
    end
    if (cmd.spd_sat) begin
      speed_nxt = signed_m[OUT_W-1:0];
    end
    if (cmd.rpm_sat) begin
      rpm_nxt = den_zero ? '0 : signed_m[RPM_W-1:0];
    end

    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PPR:  ppr_nxt  = cfg_wdata;
        REG_GEAR: gear_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ref_r     <= '0;
      delta_r   <= '0;
      speed_r   <= '0;
      rpm_r     <= '0;
      last_ms_r <= '0;
      prev_a_r  <= 1'b1;
      prev_b_r  <= 1'b1;
      ppr_r     <= PPR_RESET;
      gear_r    <= GEAR_RESET;
    end else begin
      pos_r     <= pos_nxt;
      ref_r     <= ref_nxt;
      delta_r   <= delta_nxt;
      speed_r   <= speed_nxt;
      rpm_r     <= rpm_nxt;
      last_ms_r <= last_ms_nxt;
      prev_a_r  <= prev_a_nxt;
      prev_b_r  <= prev_b_nxt;
      ppr_r     <= ppr_nxt;
      gear_r    <= gear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r  <= dt_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

  // Result reflects the state after the item; unchanged state while pushing late
  assign out_data.position            = OUT_W'(pos_nxt);
  assign out_data.window_delta        = OUT_W'(delta_nxt);
  assign out_data.speed_ticks_per_sec = speed_nxt;
  assign out_data.rpm_q8              = rpm_nxt;

  assign cfg_rdata = (cfg_sel == REG_GEAR) ? gear_r : ppr_r;

endmodule

FILE: src/qes_ctrl.sv
// Controller: sequences intake, the speed and RPM divisions and the result push.
module qes_ctrl import qes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        fifo_full,
  input  logic        cfg_wr,
  input  qes_dp_sts_t sts,
  output logic        in_ready,
  output qes_dp_cmd_t cmd
);

  qes_state_t state_r, state_nxt;
  logic       dirty_r, dirty_nxt;
  logic       pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dirty_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r | cfg_wr;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (dirty_r) begin
          // recompute RPM after a register write
          dirty_nxt = cfg_wr;
          pend_nxt  = 1'b0;
          state_nxt = ST_RPM_MAG;
        end else begin
          in_ready = !fifo_full;
          if (in_valid && !fifo_full) begin
            cmd.accept = 1'b1;
            if (sts.slow) begin
              pend_nxt  = 1'b1;
              state_nxt = ST_SPD_MAG;
            end else begin
              cmd.push = 1'b1;
            end
          end
        end
      end
      ST_SPD_MAG: begin
        cmd.spd_mag = 1'b1;
        state_nxt   = ST_SPD_LOAD;
      end
      ST_SPD_LOAD: begin
        cmd.spd_load = 1'b1;
        state_nxt    = ST_SPD_DIV;
      end
      ST_SPD_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SPD_SAT;
        end
      end
      ST_SPD_SAT: begin
        cmd.spd_sat = 1'b1;
        state_nxt   = ST_RPM_MAG;
      end
      ST_RPM_MAG: begin
        cmd.rpm_mag = 1'b1;
        state_nxt   = ST_RPM_LOAD;
      end
      ST_RPM_LOAD: begin
        cmd.rpm_load = 1'b1;
        state_nxt    = ST_RPM_DIV;
      end
      ST_RPM_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_RPM_SAT;
        end
      end
      ST_RPM_SAT: begin
        cmd.rpm_sat = 1'b1;
        state_nxt   = pend_r ? ST_PUSH : ST_IDLE;
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/qes_rsp_fifo.sv
// Two-entry result queue between the datapath and the output channel.
module qes_rsp_fifo import qes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  qes_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_ready,
  output qes_out_t out_data
);

  qes_out_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/quadrature_encoder_speed.sv
// Top level of the x4 quadrature decoder with windowed speed and RPM output.
// Each transaction on the input channel samples pins A and B, updates the
// position count and applies its command; exactly one result transaction
// follows, carrying position, window delta, speed in ticks per second and
// output shaft RPM in Q.8. Sample, clear and zero-elapsed measure items
// stream at one per clock while the result queue has room. A measure with
// elapsed time holds off input until it is done: one restoring divider
// producing one quotient bit per cycle runs first for speed and then for RPM.
// A write to pulses_per_rev or gear_ratio makes the block recompute RPM from
// the current speed, stalling input meanwhile. A two-entry result queue lets
// a new item in while an earlier result waits. Registers: pulses_per_rev at
// 0x0, gear_ratio at 0x4, both 16 bits; pready is always high.
module quadrature_encoder_speed import qes_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  qes_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output qes_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  qes_dp_cmd_t          dp_cmd;
  qes_dp_sts_t          dp_sts;
  qes_out_t             dp_out;
  logic                 fifo_full;
  logic                 cfg_wr;
  logic [CFG_REG_W-1:0] cfg_rdata;

  // Register write strobe on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = CFG_DATA_W'(cfg_rdata);

  qes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .fifo_full (fifo_full),
    .cfg_wr    (cfg_wr),
    .sts       (dp_sts),
    .in_ready  (in_ready),
    .cmd       (dp_cmd)
  );

  qes_dp #(
    .CW (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .cfg_wr    (cfg_wr),
    .cfg_sel   (paddr[2]),
    .cfg_wdata (pwdata[CFG_REG_W-1:0]),
    .cfg_rdata (cfg_rdata),
    .sts       (dp_sts),
    .out_data  (dp_out)
  );

  qes_rsp_fifo u_rsp_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dp_cmd.push),
    .push_data (dp_out),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A fast item (not a measure with elapsed time) shows its result on the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !dp_sts.slow) |=> out_valid)
    else $error("fast item produced no result");

  // A measuring item holds off the input while the divider runs
  a_slow_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && dp_sts.slow) |=> !in_ready)
    else $error("input accepted during speed computation");

  // The controller never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.push |-> !fifo_full)
    else $error("result queue overflow");

endmodule
